@@ hw/rtl/hcfp_pkg.sv @@
// Package for the hex command frame parser: parse phases, event codes and hex decoding.
`timescale 1ns / 1ps

package hcfp_pkg;

    typedef enum logic [3:0] {
        PH_START,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_SKIP,
        PH_CMD,
        PH_T_SIGN,
        PH_T_HI,
        PH_T_LO,
        PH_F_SIGN,
        PH_F_HI,
        PH_F_LO,
        PH_I_HI,
        PH_I_LO
    } t_phase;

    localparam logic [2:0] EV_TORQUE    = 3'd0;
    localparam logic [2:0] EV_ZERO      = 3'd1;
    localparam logic [2:0] EV_FAILSAFE  = 3'd2;
    localparam logic [2:0] EV_SET_ID    = 3'd3;
    localparam logic [2:0] EV_CALIBRATE = 3'd4;
    localparam logic [2:0] EV_RESET     = 3'd5;
    localparam logic [2:0] EV_REPLY_OK  = 3'd6;
    localparam logic [2:0] EV_REPLY_ERR = 3'd7;

    localparam logic [7:0] BROADCAST_ID = 8'hFF;
    localparam logic [7:0] HOST_ID      = 8'h00;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_A_LC  = 8'h61;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok     = 1'b1;
        r.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.nibble = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // Letters A to F and a to f share their low bits: value is low bits plus nine.
            r.nibble = c[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/hex_command_frame_parser.sv @@
// Top level of the hex command frame parser: one received character in, at most one event out.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+---------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_rx_char, i_motor_ready
//  out     | o_out_valid  | i_out_ready  | o_event_res, o_signed_value,
//          |              |              | o_search_magnitude, o_offset_or_id
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_data (own id)
//
// One character per cycle unless an untaken result waits; its event is registered as it is taken.
// The rate is set by the single pass from the phase and field registers to the result register.
// A waiting result does not block input when it is taken in the same cycle.
// Synchronous active-low reset sets frame start, last success and own id 1.
`timescale 1ns / 1ps

module hex_command_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_char,
    input  logic               i_motor_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_event_res,
    output logic signed [13:0] o_signed_value,
    output logic [12:0]        o_search_magnitude,
    output logic [15:0]        o_offset_or_id,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    hcfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_nibble, n_nibble;
    logic        r_sign_ok, n_sign_ok;
    logic        r_sign_neg, n_sign_neg;
    logic [23:0] r_field, n_field;
    logic [1:0]  r_count, n_count;
    logic        r_success, n_success;
    logic [7:0]  r_own_id;

    logic               r_out_valid;
    logic [2:0]         r_event;
    logic signed [13:0] r_value;
    logic [12:0]        r_search;
    logic [15:0]        r_offset;

    logic               w_accept;
    logic               w_emit;
    logic [2:0]         w_event;
    logic signed [13:0] w_value;
    logic [12:0]        w_search;
    logic [15:0]        w_offset;

    hcfp_pkg::t_hex     w_hex;
    logic [7:0]         w_byte;
    logic               w_digit_phase;
    logic               w_bad;
    logic               w_cmd;
    logic               w_succ_in;
    logic signed [13:0] w_scaled;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_hex  = hcfp_pkg::hex_decode(i_rx_char);
    assign w_byte = {r_nibble, w_hex.nibble};

    assign w_digit_phase = (r_phase == hcfp_pkg::PH_T_HI) || (r_phase == hcfp_pkg::PH_T_LO)
                        || (r_phase == hcfp_pkg::PH_F_HI) || (r_phase == hcfp_pkg::PH_F_LO)
                        || (r_phase == hcfp_pkg::PH_I_HI) || (r_phase == hcfp_pkg::PH_I_LO);
    // A failed digit inside a command is handled again as a command character.
    assign w_bad     = w_digit_phase && !w_hex.ok;
    assign w_cmd     = (r_phase == hcfp_pkg::PH_CMD) || w_bad;
    assign w_succ_in = w_bad ? 1'b0 : r_success;

    // Byte times 32, negated for a minus sign; the low-nibble byte or the failsafe limit.
    always_comb begin
        logic [7:0]  sel;
        logic [13:0] mag;
        sel = (r_phase == hcfp_pkg::PH_F_LO) ? r_field[23:16] : w_byte;
        mag = {1'b0, sel, 5'b0};
        w_scaled = r_sign_neg ? -$signed(mag) : $signed(mag);
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_cmd) begin
            case (i_rx_char)
                hcfp_pkg::CH_CR: n_phase = hcfp_pkg::PH_SKIP;
                hcfp_pkg::CH_LF: n_phase = hcfp_pkg::PH_START;
                hcfp_pkg::CH_T:  n_phase = hcfp_pkg::PH_T_SIGN;
                hcfp_pkg::CH_F:  n_phase = hcfp_pkg::PH_F_SIGN;
                hcfp_pkg::CH_I:  n_phase = hcfp_pkg::PH_I_HI;
                default:         n_phase = hcfp_pkg::PH_CMD;
            endcase
        end else begin
            unique case (r_phase)
                hcfp_pkg::PH_START: begin
                    n_phase = w_hex.ok ? hcfp_pkg::PH_ADDR_LO : hcfp_pkg::PH_ADDR_HI;
                end
                hcfp_pkg::PH_ADDR_HI: begin
                    if (w_hex.ok) begin
                        n_phase = hcfp_pkg::PH_ADDR_LO;
                    end else begin
                        n_phase = (i_rx_char == hcfp_pkg::CH_LF) ? hcfp_pkg::PH_START
                                                                 : hcfp_pkg::PH_SKIP;
                    end
                end
                hcfp_pkg::PH_ADDR_LO: begin
                    if (!w_hex.ok) begin
                        n_phase = (i_rx_char == hcfp_pkg::CH_LF) ? hcfp_pkg::PH_START
                                                                 : hcfp_pkg::PH_SKIP;
                    end else if (w_byte == r_own_id || w_byte == hcfp_pkg::BROADCAST_ID) begin
                        n_phase = hcfp_pkg::PH_CMD;
                    end else begin
                        n_phase = hcfp_pkg::PH_SKIP;
                    end
                end
                hcfp_pkg::PH_SKIP: begin
                    if (i_rx_char == hcfp_pkg::CH_LF) begin
                        n_phase = hcfp_pkg::PH_START;
                    end
                end
                hcfp_pkg::PH_T_SIGN: n_phase = hcfp_pkg::PH_T_HI;
                hcfp_pkg::PH_F_SIGN: n_phase = hcfp_pkg::PH_F_HI;
                hcfp_pkg::PH_T_HI:   n_phase = hcfp_pkg::PH_T_LO;
                hcfp_pkg::PH_F_HI:   n_phase = hcfp_pkg::PH_F_LO;
                hcfp_pkg::PH_I_HI:   n_phase = hcfp_pkg::PH_I_LO;
                hcfp_pkg::PH_T_LO:   n_phase = hcfp_pkg::PH_CMD;
                hcfp_pkg::PH_I_LO:   n_phase = hcfp_pkg::PH_CMD;
                hcfp_pkg::PH_F_LO: begin
                    n_phase = (r_count == 2'd3) ? hcfp_pkg::PH_CMD : hcfp_pkg::PH_F_HI;
                end
                default: n_phase = hcfp_pkg::PH_START;
            endcase
        end
    end

    // Results and field registers.
    always_comb begin
        n_nibble   = r_nibble;
        n_sign_ok  = r_sign_ok;
        n_sign_neg = r_sign_neg;
        n_field    = r_field;
        n_count    = r_count;
        n_success  = r_success;
        w_emit     = 1'b0;
        w_event    = hcfp_pkg::EV_TORQUE;
        w_value    = '0;
        w_search   = '0;
        w_offset   = '0;
        if (w_cmd) begin
            case (i_rx_char)
                hcfp_pkg::CH_CR, hcfp_pkg::CH_LF: begin
                    n_success = w_succ_in;
                    w_emit    = 1'b1;
                    w_event   = w_succ_in ? hcfp_pkg::EV_REPLY_OK : hcfp_pkg::EV_REPLY_ERR;
                end
                hcfp_pkg::CH_T, hcfp_pkg::CH_F, hcfp_pkg::CH_I: begin
                    n_success = w_succ_in;
                end
                hcfp_pkg::CH_Z: begin
                    n_success = 1'b1;
                    w_emit    = 1'b1;
                    w_event   = hcfp_pkg::EV_ZERO;
                end
                hcfp_pkg::CH_C: begin
                    n_success = 1'b1;
                    w_emit    = 1'b1;
                    w_event   = hcfp_pkg::EV_CALIBRATE;
                end
                hcfp_pkg::CH_R: begin
                    n_success = 1'b1;
                    w_emit    = 1'b1;
                    w_event   = hcfp_pkg::EV_RESET;
                end
                hcfp_pkg::CH_A_LC: n_success = 1'b1;
                default:           n_success = 1'b0;
            endcase
        end else begin
            unique case (r_phase)
                hcfp_pkg::PH_START, hcfp_pkg::PH_ADDR_HI: begin
                    if (w_hex.ok) begin
                        n_nibble = w_hex.nibble;
                    end
                end
                hcfp_pkg::PH_ADDR_LO: begin
                    if (w_hex.ok && (w_byte == r_own_id || w_byte == hcfp_pkg::BROADCAST_ID))
                    begin
                        n_success = 1'b1;
                    end
                end
                hcfp_pkg::PH_T_SIGN, hcfp_pkg::PH_F_SIGN: begin
                    n_sign_ok  = (i_rx_char == hcfp_pkg::CH_PLUS)
                              || (i_rx_char == hcfp_pkg::CH_MINUS);
                    n_sign_neg = (i_rx_char == hcfp_pkg::CH_MINUS);
                    n_field    = '0;
                    n_count    = '0;
                end
                hcfp_pkg::PH_T_HI, hcfp_pkg::PH_F_HI, hcfp_pkg::PH_I_HI: begin
                    n_nibble = w_hex.nibble;
                end
                hcfp_pkg::PH_T_LO: begin
                    if (!i_motor_ready) begin
                        n_success = 1'b0;
                        w_emit    = 1'b1;
                        w_event   = hcfp_pkg::EV_TORQUE;
                    end else if (!r_sign_ok) begin
                        n_success = 1'b0;
                    end else begin
                        n_success = 1'b1;
                        w_emit    = 1'b1;
                        w_event   = hcfp_pkg::EV_TORQUE;
                        w_value   = w_scaled;
                    end
                end
                hcfp_pkg::PH_F_LO: begin
                    n_field = {r_field[15:0], w_byte};
                    n_count = r_count + 2'd1;
                    if (r_count == 2'd3) begin
                        n_success = r_sign_ok;
                        w_emit    = r_sign_ok;
                        w_event   = hcfp_pkg::EV_FAILSAFE;
                        w_value   = w_scaled;
                        w_search  = {r_field[15:8], 5'b0};
                        w_offset  = {r_field[7:0], w_byte};
                    end
                end
                hcfp_pkg::PH_I_LO: begin
                    if (w_byte == hcfp_pkg::HOST_ID || w_byte == hcfp_pkg::BROADCAST_ID) begin
                        n_success = 1'b0;
                    end else begin
                        n_success = 1'b1;
                        w_emit    = 1'b1;
                        w_event   = hcfp_pkg::EV_SET_ID;
                        w_offset  = {8'd0, w_byte};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hcfp_pkg::PH_START;
            r_nibble   <= '0;
            r_sign_ok  <= 1'b0;
            r_sign_neg <= 1'b0;
            r_field    <= '0;
            r_count    <= '0;
            r_success  <= 1'b1;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_nibble   <= n_nibble;
            r_sign_ok  <= n_sign_ok;
            r_sign_neg <= n_sign_neg;
            r_field    <= n_field;
            r_count    <= n_count;
            r_success  <= n_success;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event  <= w_event;
            r_value  <= w_value;
            r_search <= w_search;
            r_offset <= w_offset;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_event;
    assign o_signed_value     = r_value;
    assign o_search_magnitude = r_search;
    assign o_offset_or_id     = r_offset;

endmodule
